FILE: rtl/per_key_top_five_average_macros.svh
// Assertion macros for the per-key top-five average RTL.
// Depends on nothing; files that check their own logic include it.
`ifndef PER_KEY_TOP_FIVE_AVERAGE_MACROS_SVH
`define PER_KEY_TOP_FIVE_AVERAGE_MACROS_SVH
`ifndef SYNTHESIS
// Check a consequence in the same cycle as its cause.
`define PKTFA_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Check a consequence in the cycle after its cause.
`define PKTFA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define PKTFA_ASSERT_SAME(label, clk, rst_n, ante, cons, msg)
`define PKTFA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

FILE: rtl/pktfa_pkg.sv
// Shared types and constants for the per-key top-five average block.
// Used by the controller, the datapath and the top level.
package pktfa_pkg;

    // Field widths of the input and result words
    localparam int KEY_W   = 31;
    localparam int SCORE_W = 16;
    localparam int AVG_W   = 20;
    localparam int KCNT_W  = 3;
    localparam int STAT_W  = 2;
    localparam int FRAC_W  = 4;

    // Result status codes
    localparam logic [STAT_W-1:0] ST_TAKEN = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] ST_ENTRY = 2'd2;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd3;

    // Input command codes
    localparam logic CMD_ADD    = 1'b0;
    localparam logic CMD_REPORT = 1'b1;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;       // latch the input word, clear index and search flags
        logic idx_inc;    // advance the slot index
        logic scan_step;  // one step of the key search
        logic decide;     // apply the add: append, new slot or table full
        logic sub_clr;    // clear the score position and the score sum
        logic min_step;   // one step of the minimum search
        logic repl;       // replace the minimum if the new score is larger
        logic rpt_empty;  // stage the empty-report result
        logic hdr;        // latch key and count of the reported slot
        logic sum_step;   // one step of the score sum
        logic div_go;     // start the average divider
        logic rpt_res;    // stage the report result, free the slot
        logic emit;       // move the staged result into the output register
    } t_dp_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic cmd_rpt;
        logic scan_done;
        logic need_min;
        logic min_done;
        logic empty;
        logic slot_valid;
        logic sum_done;
        logic div_busy;
        logic out_free;
        logic res_last;
    } t_dp_sts;

endpackage

FILE: rtl/pktfa_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies; instanced for keys, counts and kept scores.
module pktfa_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/pktfa_div.sv
// Bit-serial restoring divider: one quotient bit per cycle.
// No dependencies; used by the datapath for the Q4 average.
module pktfa_div #(
    parameter int DIVIDEND_W = 23,
    parameter int DIVISOR_W  = 3
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [DIVIDEND_W-1:0] i_dividend,
    input  logic [DIVISOR_W-1:0]  i_divisor,
    output logic                  o_busy,
    output logic [DIVIDEND_W-1:0] o_quotient
);

    localparam int CW = $clog2(DIVIDEND_W + 1);

    logic                  r_busy;
    logic [CW-1:0]         r_cnt;
    logic [DIVIDEND_W-1:0] r_quo;
    logic [DIVISOR_W-1:0]  r_rem;
    logic [DIVISOR_W-1:0]  r_dvs;
    logic [DIVISOR_W:0]    w_trial;
    logic [DIVISOR_W:0]    w_diff;
    logic                  w_ge;

    // Shift in the next dividend bit and try the subtract
    assign w_trial = {r_rem, r_quo[DIVIDEND_W-1]};
    assign w_diff  = w_trial - {1'b0, r_dvs};
    assign w_ge    = (w_trial >= {1'b0, r_dvs});

    // Control: stay busy until every dividend bit has been shifted through
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CW'(DIVIDEND_W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CW'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    // Datapath: remainder and quotient shift register
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[DIVIDEND_W-2:0], w_ge};
            r_rem <= w_ge ? w_diff[DIVISOR_W-1:0] : w_trial[DIVISOR_W-1:0];
        end
    end

    assign o_busy     = r_busy;
    assign o_quotient = r_quo;

endmodule

FILE: rtl/pktfa_dp.sv
// Datapath: key, count and score memories, search trackers, sum, divider
// and result registers. Depends on pktfa_pkg, pktfa_ram, pktfa_div and the macros header.
`include "per_key_top_five_average_macros.svh"
module pktfa_dp #(
    parameter int TABLE_ENTRIES = 16,
    parameter int TOP_K         = 5
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  pktfa_pkg::t_dp_cmd            i_cmd,
    output pktfa_pkg::t_dp_sts            o_sts,
    input  logic                          i_cmd_bit,
    input  logic [pktfa_pkg::KEY_W-1:0]   i_student_id,
    input  logic [pktfa_pkg::SCORE_W-1:0] i_score,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [pktfa_pkg::STAT_W-1:0]  o_status,
    output logic [pktfa_pkg::KEY_W-1:0]   o_key_out,
    output logic [pktfa_pkg::AVG_W-1:0]   o_average_q4,
    output logic [pktfa_pkg::KCNT_W-1:0]  o_kept_count,
    output logic                          o_last
);

    localparam int SLOT_W  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int IDX_W   = $clog2(TABLE_ENTRIES + 1);
    localparam int SDEPTH  = TABLE_ENTRIES * TOP_K;
    localparam int SADDR_W = (SDEPTH > 1) ? $clog2(SDEPTH) : 1;
    localparam int CNT_W   = $clog2(TOP_K + 1);
    localparam int POS_W   = (TOP_K > 1) ? $clog2(TOP_K) : 1;
    localparam int SUM_W   = pktfa_pkg::SCORE_W + $clog2(TOP_K);
    localparam int DIV_W   = SUM_W + pktfa_pkg::FRAC_W;

    // Address of score position j of slot s
    function automatic logic [SADDR_W-1:0] f_saddr(input logic [SLOT_W-1:0] s,
                                                   input logic [CNT_W-1:0] j);
        return SADDR_W'(s) * SADDR_W'(TOP_K) + SADDR_W'(j);
    endfunction

    // Latched input word
    logic                          r_cmd;
    logic [pktfa_pkg::KEY_W-1:0]   r_key;
    logic [pktfa_pkg::SCORE_W-1:0] r_score;

    // Table occupancy and walk state
    logic [TABLE_ENTRIES-1:0] r_valid;
    logic [IDX_W-1:0]         r_idx;
    logic                     r_found;
    logic [SLOT_W-1:0]        r_found_slot;
    logic [CNT_W-1:0]         r_fcnt;
    logic                     r_free;
    logic [SLOT_W-1:0]        r_free_slot;
    logic [CNT_W-1:0]         r_sub;
    logic [pktfa_pkg::SCORE_W-1:0] r_min;
    logic [POS_W-1:0]         r_min_pos;
    logic [SUM_W-1:0]         r_sum;

    // Staged result and output register
    logic [pktfa_pkg::STAT_W-1:0] r_res_status;
    logic [pktfa_pkg::KEY_W-1:0]  r_res_key;
    logic [pktfa_pkg::AVG_W-1:0]  r_res_avg;
    logic [pktfa_pkg::KCNT_W-1:0] r_res_cnt;
    logic                         r_res_last;
    logic                         r_o_valid;
    logic [pktfa_pkg::STAT_W-1:0] r_o_status;
    logic [pktfa_pkg::KEY_W-1:0]  r_o_key;
    logic [pktfa_pkg::AVG_W-1:0]  r_o_avg;
    logic [pktfa_pkg::KCNT_W-1:0] r_o_cnt;
    logic                         r_o_last;

    // Memory ports
    logic [pktfa_pkg::KEY_W-1:0]   w_key_rd;
    logic [CNT_W-1:0]              w_cnt_rd;
    logic [pktfa_pkg::SCORE_W-1:0] w_score_rd;
    logic                          w_cnt_we;
    logic [SLOT_W-1:0]             w_cnt_waddr;
    logic [CNT_W-1:0]              w_cnt_wdata;
    logic                          w_score_we;
    logic [SADDR_W-1:0]            w_score_waddr;
    logic [SADDR_W-1:0]            w_score_raddr;
    logic                          w_key_we;

    // Misc
    logic [SLOT_W-1:0]        w_slot;
    logic [SLOT_W-1:0]        w_prev;
    logic                     w_found_small;
    logic                     w_take_new;
    logic                     w_replace;
    logic [CNT_W-1:0]         w_cnt_inc;
    logic [TABLE_ENTRIES-1:0] w_above;
    logic                     w_last;
    logic                     w_out_free;
    logic                     w_div_busy;
    logic [DIV_W-1:0]         w_quotient;

    assign w_slot        = r_idx[SLOT_W-1:0];
    assign w_prev        = SLOT_W'(r_idx - 1'b1);
    assign w_found_small = r_found && (r_fcnt < CNT_W'(TOP_K));
    assign w_take_new    = !r_found && r_free;
    assign w_replace     = r_score > r_min;
    assign w_cnt_inc     = r_fcnt + 1'b1;
    assign w_out_free    = !r_o_valid || !i_stall;

    // Mark slots above the current index; the report ends at the highest valid one
    always_comb begin
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            w_above[i] = (IDX_W'(i) > r_idx);
        end
    end
    assign w_last = ((r_valid & w_above) == '0);

    // Memory write selects
    assign w_key_we    = i_cmd.decide && w_take_new;
    assign w_cnt_we    = i_cmd.decide && (w_found_small || w_take_new);
    assign w_cnt_waddr = w_found_small ? r_found_slot : r_free_slot;
    assign w_cnt_wdata = w_found_small ? w_cnt_inc : CNT_W'(1);
    assign w_score_we  = (i_cmd.decide && (w_found_small || w_take_new))
                      || (i_cmd.repl && w_replace);

    always_comb begin
        if (i_cmd.repl) begin
            w_score_waddr = f_saddr(r_found_slot, CNT_W'(r_min_pos));
        end else if (w_found_small) begin
            w_score_waddr = f_saddr(r_found_slot, r_fcnt);
        end else begin
            w_score_waddr = f_saddr(r_free_slot, '0);
        end
    end

    assign w_score_raddr = r_cmd ? f_saddr(w_slot, r_sub) : f_saddr(r_found_slot, r_sub);

    pktfa_ram #(.WIDTH(pktfa_pkg::KEY_W), .DEPTH(TABLE_ENTRIES)) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (w_key_we),
        .i_waddr (r_free_slot),
        .i_wdata (r_key),
        .i_raddr (w_slot),
        .o_rdata (w_key_rd)
    );

    pktfa_ram #(.WIDTH(CNT_W), .DEPTH(TABLE_ENTRIES)) u_cnt_ram (
        .i_clk   (i_clk),
        .i_we    (w_cnt_we),
        .i_waddr (w_cnt_waddr),
        .i_wdata (w_cnt_wdata),
        .i_raddr (w_slot),
        .o_rdata (w_cnt_rd)
    );

    pktfa_ram #(.WIDTH(pktfa_pkg::SCORE_W), .DEPTH(SDEPTH)) u_score_ram (
        .i_clk   (i_clk),
        .i_we    (w_score_we),
        .i_waddr (w_score_waddr),
        .i_wdata (r_score),
        .i_raddr (w_score_raddr),
        .o_rdata (w_score_rd)
    );

    pktfa_div #(.DIVIDEND_W(DIV_W), .DIVISOR_W(CNT_W)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_go),
        .i_dividend ({r_sum, {pktfa_pkg::FRAC_W{1'b0}}}),
        .i_divisor  (r_fcnt),
        .o_busy     (w_div_busy),
        .o_quotient (w_quotient)
    );

    // Hold the input word; a report header replaces the key with the slot's key
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cmd   <= i_cmd_bit;
            r_key   <= i_student_id;
            r_score <= i_score;
        end else if (i_cmd.hdr) begin
            r_key <= w_key_rd;
        end
    end

    // Walk the table: slot index and key search trackers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_found <= 1'b0;
            r_free  <= 1'b0;
        end else if (i_cmd.load) begin
            r_idx   <= '0;
            r_found <= 1'b0;
            r_free  <= 1'b0;
        end else if (i_cmd.idx_inc) begin
            r_idx <= r_idx + 1'b1;
        end else if (i_cmd.scan_step) begin
            if (r_idx != '0) begin
                if (r_valid[w_prev]) begin
                    if (!r_found && w_key_rd == r_key) begin
                        r_found      <= 1'b1;
                        r_found_slot <= w_prev;
                    end
                end else if (!r_free) begin
                    r_free      <= 1'b1;
                    r_free_slot <= w_prev;
                end
            end
            if (r_idx != IDX_W'(TABLE_ENTRIES)) begin
                r_idx <= r_idx + 1'b1;
            end
        end
    end

    // Count of the matched or reported slot
    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_step && r_idx != '0 && r_valid[w_prev] && !r_found
                && w_key_rd == r_key) begin
            r_fcnt <= w_cnt_rd;
        end else if (i_cmd.hdr) begin
            r_fcnt <= w_cnt_rd;
        end
    end

    // Step through score positions: minimum search and sum
    always_ff @(posedge i_clk) begin
        if (i_cmd.sub_clr || i_cmd.hdr) begin
            r_sub <= '0;
            r_sum <= '0;
        end else if (i_cmd.min_step) begin
            if (r_sub != '0 && (r_sub == CNT_W'(1) || w_score_rd < r_min)) begin
                r_min     <= w_score_rd;
                r_min_pos <= POS_W'(r_sub - 1'b1);
            end
            if (r_sub != CNT_W'(TOP_K)) begin
                r_sub <= r_sub + 1'b1;
            end
        end else if (i_cmd.sum_step) begin
            if (r_sub != '0) begin
                r_sum <= r_sum + SUM_W'(w_score_rd);
            end
            if (r_sub != r_fcnt) begin
                r_sub <= r_sub + 1'b1;
            end
        end
    end

    // Occupancy: take a slot on a new key, free it once reported
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_cmd.decide && w_take_new) begin
            r_valid[r_free_slot] <= 1'b1;
        end else if (i_cmd.rpt_res) begin
            r_valid[w_slot] <= 1'b0;
        end
    end

    // Stage the next result word
    always_ff @(posedge i_clk) begin
        if (i_cmd.decide) begin
            r_res_status <= (r_found || r_free) ? pktfa_pkg::ST_TAKEN : pktfa_pkg::ST_FULL;
            r_res_key    <= r_key;
            r_res_avg    <= '0;
            r_res_last   <= 1'b1;
            if (w_found_small) begin
                r_res_cnt <= pktfa_pkg::KCNT_W'(w_cnt_inc);
            end else if (w_take_new) begin
                r_res_cnt <= pktfa_pkg::KCNT_W'(1);
            end else begin
                r_res_cnt <= '0;
            end
        end else if (i_cmd.repl) begin
            r_res_status <= pktfa_pkg::ST_TAKEN;
            r_res_key    <= r_key;
            r_res_avg    <= '0;
            r_res_cnt    <= pktfa_pkg::KCNT_W'(r_fcnt);
            r_res_last   <= 1'b1;
        end else if (i_cmd.rpt_empty) begin
            r_res_status <= pktfa_pkg::ST_EMPTY;
            r_res_key    <= '0;
            r_res_avg    <= '0;
            r_res_cnt    <= '0;
            r_res_last   <= 1'b1;
        end else if (i_cmd.rpt_res) begin
            r_res_status <= pktfa_pkg::ST_ENTRY;
            r_res_key    <= r_key;
            r_res_avg    <= pktfa_pkg::AVG_W'(w_quotient);
            r_res_cnt    <= pktfa_pkg::KCNT_W'(r_fcnt);
            r_res_last   <= w_last;
        end
    end

    // Output register: load a staged word, drop valid once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_o_valid <= 1'b1;
        end else if (!i_stall) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_o_status <= r_res_status;
            r_o_key    <= r_res_key;
            r_o_avg    <= r_res_avg;
            r_o_cnt    <= r_res_cnt;
            r_o_last   <= r_res_last;
        end
    end

    assign o_valid      = r_o_valid;
    assign o_status     = r_o_status;
    assign o_key_out    = r_o_key;
    assign o_average_q4 = r_o_avg;
    assign o_kept_count = r_o_cnt;
    assign o_last       = r_o_last;

    // Status to the controller
    assign o_sts.cmd_rpt    = r_cmd;
    assign o_sts.scan_done  = (r_idx == IDX_W'(TABLE_ENTRIES));
    assign o_sts.need_min   = r_found && !w_found_small;
    assign o_sts.min_done   = (r_sub == CNT_W'(TOP_K));
    assign o_sts.empty      = (r_valid == '0);
    assign o_sts.slot_valid = r_valid[w_slot];
    assign o_sts.sum_done   = (r_sub == r_fcnt);
    assign o_sts.div_busy   = w_div_busy;
    assign o_sts.out_free   = w_out_free;
    assign o_sts.res_last   = r_res_last;

    `PKTFA_ASSERT_SAME(a_new_slot_free, i_clk, i_rst_n, i_cmd.decide && w_take_new, !r_valid[r_free_slot], "new key placed in an occupied slot")
    `PKTFA_ASSERT_SAME(a_report_valid, i_clk, i_rst_n, i_cmd.rpt_res, r_valid[w_slot], "report of a free slot")
    `PKTFA_ASSERT_SAME(a_emit_free, i_clk, i_rst_n, i_cmd.emit, w_out_free, "result loaded over a stalled word")
    `PKTFA_ASSERT_NEXT(a_div_runs, i_clk, i_rst_n, i_cmd.div_go, w_div_busy, "divider did not start")

endmodule

FILE: rtl/pktfa_ctrl.sv
// Controller state machine: sequences add and report operations.
// Depends on pktfa_pkg for the command and status structs.
module pktfa_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  pktfa_pkg::t_dp_sts i_sts,
    output pktfa_pkg::t_dp_cmd o_cmd
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_DISP   = 4'd1;
    localparam logic [3:0] S_SCAN   = 4'd2;
    localparam logic [3:0] S_DECIDE = 4'd3;
    localparam logic [3:0] S_MIN    = 4'd4;
    localparam logic [3:0] S_REPL   = 4'd5;
    localparam logic [3:0] S_RPT    = 4'd6;
    localparam logic [3:0] S_SEEK   = 4'd7;
    localparam logic [3:0] S_HDR    = 4'd8;
    localparam logic [3:0] S_SUM    = 4'd9;
    localparam logic [3:0] S_DIVGO  = 4'd10;
    localparam logic [3:0] S_DIVW   = 4'd11;
    localparam logic [3:0] S_EMIT   = 4'd12;
    localparam logic [3:0] S_NEXT   = 4'd13;

    logic [3:0] r_state;
    logic [3:0] n_state;

    // Next state and datapath commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DISP;
                end
            end
            S_DISP: begin
                n_state = i_sts.cmd_rpt ? S_RPT : S_SCAN;
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_sts.scan_done) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (i_sts.need_min) begin
                    o_cmd.sub_clr = 1'b1;
                    n_state       = S_MIN;
                end else begin
                    o_cmd.decide = 1'b1;
                    n_state      = S_EMIT;
                end
            end
            S_MIN: begin
                o_cmd.min_step = 1'b1;
                if (i_sts.min_done) begin
                    n_state = S_REPL;
                end
            end
            S_REPL: begin
                o_cmd.repl = 1'b1;
                n_state    = S_EMIT;
            end
            S_RPT: begin
                if (i_sts.empty) begin
                    o_cmd.rpt_empty = 1'b1;
                    n_state         = S_EMIT;
                end else begin
                    n_state = S_SEEK;
                end
            end
            S_SEEK: begin
                if (i_sts.slot_valid) begin
                    n_state = S_HDR;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                end
            end
            S_HDR: begin
                o_cmd.hdr = 1'b1;
                n_state   = S_SUM;
            end
            S_SUM: begin
                o_cmd.sum_step = 1'b1;
                if (i_sts.sum_done) begin
                    n_state = S_DIVGO;
                end
            end
            S_DIVGO: begin
                o_cmd.div_go = 1'b1;
                n_state      = S_DIVW;
            end
            S_DIVW: begin
                if (!i_sts.div_busy) begin
                    o_cmd.rpt_res = 1'b1;
                    n_state       = S_EMIT;
                end
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = i_sts.res_last ? S_IDLE : S_NEXT;
                end
            end
            S_NEXT: begin
                o_cmd.idx_inc = 1'b1;
                n_state       = S_SEEK;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_stall = (r_state != S_IDLE);

endmodule

FILE: rtl/per_key_top_five_average.sv
// Channel   Dir  Handshake          Word
// input     in   i_valid / o_stall  i_cmd, i_student_id, i_score
// result    out  o_valid / i_stall  o_status, o_key_out, o_average_q4, o_kept_count, o_last
//
// Add: a key search over the key memory, one slot a cycle; a key that already
//   holds TOP_K scores adds a minimum search over its kept scores.
// Report: each occupied slot is handled by a score sum and the bit-serial divider
//   over DIV_W = 16 + clog2(TOP_K) + 4 bits.
// Reset clears the occupancy bits, not the memories; no memory clearing pass is needed.
// The output register holds a result under stall; the next word is taken once the
//   last result of the current one is loaded into it.
// Top level of the per-key top-five average block; depends on pktfa_pkg,
// pktfa_ctrl and pktfa_dp.
module per_key_top_five_average #(
    parameter int TABLE_ENTRIES = 16,
    parameter int TOP_K         = 5
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic                          i_cmd,
    input  logic [pktfa_pkg::KEY_W-1:0]   i_student_id,
    input  logic [pktfa_pkg::SCORE_W-1:0] i_score,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [pktfa_pkg::STAT_W-1:0]  o_status,
    output logic [pktfa_pkg::KEY_W-1:0]   o_key_out,
    output logic [pktfa_pkg::AVG_W-1:0]   o_average_q4,
    output logic [pktfa_pkg::KCNT_W-1:0]  o_kept_count,
    output logic                          o_last
);

    pktfa_pkg::t_dp_cmd w_cmd;
    pktfa_pkg::t_dp_sts w_sts;

    // Sequence each word
    pktfa_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    // Table storage, arithmetic and result register
    pktfa_dp #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .TOP_K         (TOP_K)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_sts        (w_sts),
        .i_cmd_bit    (i_cmd),
        .i_student_id (i_student_id),
        .i_score      (i_score),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_status     (o_status),
        .o_key_out    (o_key_out),
        .o_average_q4 (o_average_q4),
        .o_kept_count (o_kept_count),
        .o_last       (o_last)
    );

endmodule

FILE: tb/per_key_top_five_average_tb.sv
// Self-checking testbench for the per-key top-five average block: random and directed
// words against a table-based predictor of keys, kept scores and Q4 averages.
// Depends on pktfa_pkg and per_key_top_five_average.
`timescale 1ns / 100ps

// One result word as seen on the output ports
typedef struct packed {
    logic [pktfa_pkg::STAT_W-1:0] status;
    logic [pktfa_pkg::KEY_W-1:0]  key;
    logic [pktfa_pkg::AVG_W-1:0]  avg;
    logic [pktfa_pkg::KCNT_W-1:0] cnt;
    logic                         last;
} t_avg_result;

// Predicts the result words of each accepted word and checks the block against them
class t_top_five_averager #(int SLOTS = 16, int KEEP = 5);
    logic                          slot_used  [SLOTS];
    logic [pktfa_pkg::KEY_W-1:0]   slot_key   [SLOTS];
    int unsigned                   slot_cnt   [SLOTS];
    logic [pktfa_pkg::SCORE_W-1:0] slot_score [SLOTS][KEEP];
    t_avg_result                   pending_results [$];
    int unsigned                   mismatch_cnt;

    function new();
        foreach (slot_used[s]) slot_used[s] = 1'b0;
        mismatch_cnt = 0;
    endfunction

    function int pending();
        return pending_results.size();
    endfunction

    // Print one line per mismatch and count it
    task report(string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        mismatch_cnt++;
    endtask

    function void push_result(logic [pktfa_pkg::STAT_W-1:0] st,
                              logic [pktfa_pkg::KEY_W-1:0] key,
                              logic [pktfa_pkg::AVG_W-1:0] avg, int unsigned cnt, logic last);
        t_avg_result r;
        r.status = st;
        r.key    = key;
        r.avg    = avg;
        r.cnt    = pktfa_pkg::KCNT_W'(cnt);
        r.last   = last;
        pending_results.insert(pending_results.size(), r);
    endfunction

    // Truncated Q4 mean of the kept scores of one slot
    function logic [pktfa_pkg::AVG_W-1:0] mean_q4(int s);
        logic [31:0] total;
        total = 0;
        for (int i = 0; i < slot_cnt[s]; i++) total += slot_score[s][i];
        return pktfa_pkg::AVG_W'((total << pktfa_pkg::FRAC_W) / slot_cnt[s]);
    endfunction

    // Update the table for one accepted word and queue the words it causes
    function void note_word(logic cmd, logic [pktfa_pkg::KEY_W-1:0] key,
                            logic [pktfa_pkg::SCORE_W-1:0] score);
        int hit;
        int spare;
        int last_used;
        int low_pos;
        logic [pktfa_pkg::SCORE_W-1:0] low_val;
        hit = -1;
        spare = -1;
        last_used = -1;
        if (cmd == pktfa_pkg::CMD_REPORT) begin
            for (int s = 0; s < SLOTS; s++) if (slot_used[s]) last_used = s;
            if (last_used < 0) begin
                push_result(pktfa_pkg::ST_EMPTY, '0, '0, 0, 1'b1);
                return;
            end
            // Emit in slot order and free each slot as it goes out
            for (int s = 0; s < SLOTS; s++) begin
                if (slot_used[s]) begin
                    push_result(pktfa_pkg::ST_ENTRY, slot_key[s], mean_q4(s), slot_cnt[s],
                                s == last_used);
                    slot_used[s] = 1'b0;
                end
            end
            return;
        end
        for (int s = 0; s < SLOTS; s++) begin
            if (slot_used[s]) begin
                if (hit < 0 && slot_key[s] == key) hit = s;
            end else if (spare < 0) begin
                spare = s;
            end
        end
        if (hit >= 0) begin
            if (slot_cnt[hit] < KEEP) begin
                slot_score[hit][slot_cnt[hit]] = score;
                slot_cnt[hit]++;
            end else begin
                // Replace the first smallest score only when strictly beaten
                low_pos = 0;
                low_val = slot_score[hit][0];
                for (int i = 1; i < KEEP; i++) begin
                    if (slot_score[hit][i] < low_val) begin
                        low_val = slot_score[hit][i];
                        low_pos = i;
                    end
                end
                if (score > low_val) slot_score[hit][low_pos] = score;
            end
            push_result(pktfa_pkg::ST_TAKEN, key, '0, slot_cnt[hit], 1'b1);
        end else if (spare >= 0) begin
            slot_used[spare]     = 1'b1;
            slot_key[spare]      = key;
            slot_cnt[spare]      = 1;
            slot_score[spare][0] = score;
            push_result(pktfa_pkg::ST_TAKEN, key, '0, 1, 1'b1);
        end else begin
            push_result(pktfa_pkg::ST_FULL, key, '0, 0, 1'b1);
        end
    endfunction

    // Compare one accepted result word with the oldest prediction
    task check_result(t_avg_result got);
        t_avg_result want;
        if (pending_results.size() == 0) begin
            report($sformatf("unexpected word status %0d key %h", got.status, got.key));
            return;
        end
        want = pending_results.pop_front();
        if (got.status !== want.status)
            report($sformatf("status %0d, want %0d (key %h)", got.status, want.status, want.key));
        if (got.key !== want.key)
            report($sformatf("key %h, want %h", got.key, want.key));
        if (got.avg !== want.avg)
            report($sformatf("average %h, want %h (key %h)", got.avg, want.avg, want.key));
        if (got.cnt !== want.cnt)
            report($sformatf("count %0d, want %0d (key %h)", got.cnt, want.cnt, want.key));
        if (got.last !== want.last)
            report($sformatf("last %b, want %b (key %h)", got.last, want.last, want.key));
    endtask
endclass

module per_key_top_five_average_tb;

    localparam int TABLE_ENTRIES = 16;
    localparam int TOP_K         = 5;
    localparam int RANDOM_WORDS  = 215;
    localparam int HOLD_CYCLES   = 400;
    localparam int IDLE_LIMIT    = 6000;
    localparam int TAIL_CYCLES   = 60;

    logic                          i_clk        = 1'b0;
    logic                          i_rst_n      = 1'b0;
    logic                          i_valid      = 1'b0;
    logic                          o_stall;
    logic                          i_cmd        = pktfa_pkg::CMD_ADD;
    logic [pktfa_pkg::KEY_W-1:0]   i_student_id = '0;
    logic [pktfa_pkg::SCORE_W-1:0] i_score      = '0;
    logic                          o_valid;
    logic                          i_stall      = 1'b0;
    logic [pktfa_pkg::STAT_W-1:0]  o_status;
    logic [pktfa_pkg::KEY_W-1:0]   o_key_out;
    logic [pktfa_pkg::AVG_W-1:0]   o_average_q4;
    logic [pktfa_pkg::KCNT_W-1:0]  o_kept_count;
    logic                          o_last;

    t_top_five_averager #(TABLE_ENTRIES, TOP_K) averager;

    bit calm     = 1'b0;
    bit hold_req = 1'b0;
    int words_sent = 0;

    per_key_top_five_average #(
        .TABLE_ENTRIES(TABLE_ENTRIES),
        .TOP_K(TOP_K)
    ) u_dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .i_cmd(i_cmd),
        .i_student_id(i_student_id),
        .i_score(i_score),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .o_status(o_status),
        .o_key_out(o_key_out),
        .o_average_q4(o_average_q4),
        .o_kept_count(o_kept_count),
        .o_last(o_last)
    );

    // 8 ns clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Idle cycles after a word: mostly none or short, now and then long
    function int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Scores lean on the extremes and on small values that tie
    function logic [pktfa_pkg::SCORE_W-1:0] pick_score();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return '0;
        if (r == 1) return '1;
        if (r < 4) return pktfa_pkg::SCORE_W'($urandom_range(0, 15));
        return pktfa_pkg::SCORE_W'($urandom);
    endfunction

    function logic [pktfa_pkg::KEY_W-1:0] pick_key();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0) return '0;
        if (r == 1) return '1;
        return pktfa_pkg::KEY_W'($urandom);
    endfunction

    // Offer one word at a falling edge, hold it until taken, then idle for the gap pick_gap chooses
    task automatic send_word(input logic cmd, input logic [pktfa_pkg::KEY_W-1:0] key,
                             input logic [pktfa_pkg::SCORE_W-1:0] score);
        int gap;
        i_valid      <= 1'b1;
        i_cmd        <= cmd;
        i_student_id <= key;
        i_score      <= score;
        do @(posedge i_clk); while (o_stall);
        averager.note_word(cmd, key, score);
        words_sent++;
        @(negedge i_clk);
        gap = pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    // Stop offering until every predicted word has come out
    task automatic drain();
        i_valid <= 1'b0;
        while (averager.pending() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Result side: check at the rising edge, choose the next stall at the falling edge
    initial begin
        t_avg_result got;
        int stall_left;
        int r;
        stall_left = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && !i_stall) begin
                got.status = o_status;
                got.key    = o_key_out;
                got.avg    = o_average_q4;
                got.cnt    = o_kept_count;
                got.last   = o_last;
                averager.check_result(got);
            end
            @(negedge i_clk);
            if (hold_req) begin
                hold_req   = 1'b0;
                stall_left = HOLD_CYCLES;
            end
            r = $urandom_range(0, 99);
            if (stall_left > 0) begin
                i_stall <= 1'b1;
                stall_left--;
            end else if (calm || r < 70) begin
                i_stall <= 1'b0;
            end else if (r < 94) begin
                i_stall    <= 1'b1;
                stall_left = $urandom_range(0, 2);
            end else begin
                i_stall    <= 1'b1;
                stall_left = $urandom_range(8, 40);
            end
        end
    end

    // End the run when nothing moves on either side for too long
    initial begin
        int idle;
        idle = 0;
        forever begin
            @(posedge i_clk);
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) idle = 0;
            else idle++;
            if (idle >= IDLE_LIMIT) begin
                $display("per_key_top_five_average_tb failed");
                $finish;
            end
        end
    end

    // Stimulus
    initial begin
        int tie_scores [7] = '{10, 20, 10, 30, 40, 10, 11};
        int round;
        int kind;
        int n_keys;
        int n_rec;
        int start_cnt;
        logic [pktfa_pkg::KEY_W-1:0] pool [20];
        logic [pktfa_pkg::KEY_W-1:0] key;

        averager = new();
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Report with nothing stored
        send_word(pktfa_pkg::CMD_REPORT, '1, '1);
        // Key zero: fill five, then a tie with the minimum, then a score just above it
        foreach (tie_scores[i])
            send_word(pktfa_pkg::CMD_ADD, '0, pktfa_pkg::SCORE_W'(tie_scores[i]));
        // Largest key with largest scores; a zero and an equal score are both left out
        repeat (5) send_word(pktfa_pkg::CMD_ADD, '1, '1);
        send_word(pktfa_pkg::CMD_ADD, '1, '0);
        send_word(pktfa_pkg::CMD_ADD, '1, '1);
        // Mean that truncates
        send_word(pktfa_pkg::CMD_ADD, pktfa_pkg::KEY_W'(31'h2AAA_5555), 16'd1);
        send_word(pktfa_pkg::CMD_ADD, pktfa_pkg::KEY_W'(31'h2AAA_5555), 16'd1);
        send_word(pktfa_pkg::CMD_ADD, pktfa_pkg::KEY_W'(31'h2AAA_5555), 16'd2);
        send_word(pktfa_pkg::CMD_REPORT, '0, '0);
        send_word(pktfa_pkg::CMD_REPORT, '0, '0);
        drain();

        // Random rounds: mostly fill-then-report sequences, some noise
        start_cnt = words_sent;
        round = 0;
        while (words_sent - start_cnt < RANDOM_WORDS) begin
            round++;
            calm = ($urandom_range(0, 4) == 0);
            kind = $urandom_range(0, 9);
            // Receiver holds off while the sender keeps offering
            if (round == 2 || round == 6) begin
                hold_req = 1'b1;
                kind     = 0;
            end
            if (kind < 7) begin
                n_keys = ($urandom_range(0, 3) == 0) ? $urandom_range(17, 20)
                                                    : $urandom_range(1, 12);
                for (int i = 0; i < n_keys; i++) pool[i] = pick_key();
                n_rec = $urandom_range(n_keys, n_keys * 4 + 6);
                if (n_rec > 45) n_rec = 45;
                for (int i = 0; i < n_rec; i++) begin
                    key = (i < n_keys) ? pool[i] : pool[$urandom_range(0, n_keys - 1)];
                    send_word(pktfa_pkg::CMD_ADD, key, pick_score());
                end
                send_word(pktfa_pkg::CMD_REPORT, pktfa_pkg::KEY_W'($urandom),
                          pktfa_pkg::SCORE_W'($urandom));
            end else if (kind < 9) begin
                repeat ($urandom_range(1, 8)) begin
                    if ($urandom_range(0, 3) == 0)
                        send_word(pktfa_pkg::CMD_REPORT, pktfa_pkg::KEY_W'($urandom),
                                  pktfa_pkg::SCORE_W'($urandom));
                    else
                        send_word(pktfa_pkg::CMD_ADD, pick_key(), pick_score());
                end
            end else begin
                send_word(pktfa_pkg::CMD_REPORT, pktfa_pkg::KEY_W'($urandom),
                          pktfa_pkg::SCORE_W'($urandom));
                send_word(pktfa_pkg::CMD_REPORT, pktfa_pkg::KEY_W'($urandom),
                          pktfa_pkg::SCORE_W'($urandom));
            end
            if (round == 2 || $urandom_range(0, 3) == 0) drain();
        end

        // Wait for the last results, then let the block settle
        calm = 1'b0;
        drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (averager.pending() != 0)
            averager.report($sformatf("%0d words never came out", averager.pending()));
        if (averager.mismatch_cnt == 0) begin
            $display("per_key_top_five_average_tb passed");
        end else begin
            $display("per_key_top_five_average_tb failed");
        end
        $finish;
    end

endmodule

FILE: per_key_top_five_average.f
+incdir+rtl
rtl/pktfa_pkg.sv
rtl/pktfa_ram.sv
rtl/pktfa_div.sv
rtl/pktfa_dp.sv
rtl/pktfa_ctrl.sv
rtl/per_key_top_five_average.sv
tb/per_key_top_five_average_tb.sv
